[rtl/trpp_pkg.sv]
// shared types and constants for the transfer record palette parser
`default_nettype none

package trpp_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned SLOT_W  = 5;
	localparam int unsigned COUNT_W = 7;

	localparam logic [BYTE_W-1:0]  END_MARK         = 8'h80;
	localparam logic [BYTE_W-1:0]  PALETTE_HIGH     = 8'h3F;
	localparam logic [COUNT_W-1:0] COUNT_FULL       = 7'd64;
	localparam logic [BYTE_W-1:0]  MAX_OFFSET_RESET = 8'h60;
	localparam logic [BYTE_W-1:0]  POSITION_MAX     = 8'hFF;

	// parser phase, one-hot
	typedef enum logic [4:0] {
		PH_HIGH    = 5'b00001,
		PH_LOW     = 5'b00010,
		PH_CTRL    = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_ENDED   = 5'b10000
	} phase_t;

	// palette write produced by one byte
	typedef struct packed {
		logic              produce;
		logic [SLOT_W-1:0] slot;
		logic [BYTE_W-1:0] color;
	} result_t;

endpackage

`default_nettype wire

[rtl/trpp_parse.sv]
// record parser state and per-byte step logic
`default_nettype none

module trpp_parse (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire logic [trpp_pkg::BYTE_W-1:0]   data_byte,
	input  wire logic                          last_byte,
	input  wire logic [trpp_pkg::BYTE_W-1:0]   max_offset,
	output trpp_pkg::result_t                  res
);

	trpp_pkg::phase_t                   phase_q, phase_d;
	logic [trpp_pkg::BYTE_W-1:0]        position_q, position_d;
	logic [trpp_pkg::SLOT_W-1:0]        slot_q, slot_d;
	logic [trpp_pkg::COUNT_W-1:0]       remaining_q, remaining_d, rem_dec;
	logic                               is_palette_q, is_palette_d;
	logic                               in_range;

	assign in_range = (position_q < max_offset);
	assign rem_dec  = (remaining_q != '0) ? remaining_q - 1'b1 : '0;

	always_comb begin
		phase_d      = phase_q;
		slot_d       = slot_q;
		remaining_d  = remaining_q;
		is_palette_d = is_palette_q;
		res.produce  = 1'b0;
		res.slot     = slot_q;
		res.color    = data_byte;
		if (in_range) begin
			unique case (phase_q)
				trpp_pkg::PH_HIGH: begin
					if (data_byte >= trpp_pkg::END_MARK) begin
						phase_d = trpp_pkg::PH_ENDED;
					end else begin
						is_palette_d = (data_byte == trpp_pkg::PALETTE_HIGH);
						phase_d      = trpp_pkg::PH_LOW;
					end
				end
				trpp_pkg::PH_LOW: begin
					slot_d  = data_byte[trpp_pkg::SLOT_W-1:0];
					phase_d = trpp_pkg::PH_CTRL;
				end
				trpp_pkg::PH_CTRL: begin
					// count of zero means a full record
					remaining_d = (data_byte[5:0] == 6'd0) ? trpp_pkg::COUNT_FULL
						: {1'b0, data_byte[5:0]};
					phase_d = trpp_pkg::PH_PAYLOAD;
				end
				trpp_pkg::PH_PAYLOAD: begin
					res.produce = is_palette_q;
					slot_d      = slot_q + 1'b1;
					remaining_d = rem_dec;
					if (rem_dec == '0) begin
						phase_d = trpp_pkg::PH_HIGH;
					end
				end
				default: begin
				end
			endcase
		end
		position_d = (position_q < trpp_pkg::POSITION_MAX) ? position_q + 1'b1 : position_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= trpp_pkg::PH_HIGH;
			position_q   <= '0;
			slot_q       <= '0;
			remaining_q  <= '0;
			is_palette_q <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				phase_q      <= trpp_pkg::PH_HIGH;
				position_q   <= '0;
				slot_q       <= '0;
				remaining_q  <= '0;
				is_palette_q <= 1'b0;
			end else begin
				phase_q      <= phase_d;
				position_q   <= position_d;
				slot_q       <= slot_d;
				remaining_q  <= remaining_d;
				is_palette_q <= is_palette_d;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/trpp_out_reg.sv]
// result register with valid and stall towards the consumer
`default_nettype none

module trpp_out_reg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          load,
	input  wire trpp_pkg::result_t             res,
	input  wire logic                          out_stall,
	output logic                               out_valid,
	output logic [trpp_pkg::SLOT_W-1:0]        palette_slot,
	output logic [trpp_pkg::BYTE_W-1:0]        color_index
);

	logic                         valid_q;
	logic [trpp_pkg::SLOT_W-1:0]  slot_q;
	logic [trpp_pkg::BYTE_W-1:0]  color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (valid_q && !out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q  <= res.slot;
			color_q <= res.color;
		end
	end

	assign out_valid    = valid_q;
	assign palette_slot = slot_q;
	assign color_index  = color_q;

endmodule

`default_nettype wire

[rtl/transfer_record_palette_parser.sv]
// top level of the transfer record palette parser
// a byte is held in the input register, then its palette write in the result register
// throughput: one byte per cycle, limited only by the consumer stalling a palette write
// a byte that gives no palette write never waits on the consumer
// reset: arst_n clears the parser state, both valid flags and sets max_offset to 0x60
// the byte that carries last_byte returns the parser to its reset state, max_offset kept
`default_nettype none

module transfer_record_palette_parser (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// byte stream in
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [trpp_pkg::BYTE_W-1:0]   data_byte,
	input  wire logic                          last_byte,
	// palette writes out
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [trpp_pkg::SLOT_W-1:0]        palette_slot,
	output logic [trpp_pkg::BYTE_W-1:0]        color_index,
	// max_offset register write
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [trpp_pkg::BYTE_W-1:0]   cfg_data
);

	// configuration register, always writable
	logic [trpp_pkg::BYTE_W-1:0] max_offset_q;

	// input register stage
	logic                         in_valid_s1;
	logic [trpp_pkg::BYTE_W-1:0]  data_byte_s1;
	logic                         last_byte_s1;

	trpp_pkg::result_t            res;
	logic                         advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_offset_q <= trpp_pkg::MAX_OFFSET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_offset_q <= cfg_data;
		end
	end

	// the held byte moves on unless it makes a palette write that the
	// result register cannot take this cycle
	assign advance  = in_valid_s1 && (!res.produce || !out_valid || !out_stall);
	assign in_stall = in_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_byte_s1 <= data_byte;
			last_byte_s1 <= last_byte;
		end
	end

	// parser state updates once per byte as it leaves the input stage
	trpp_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.data_byte  (data_byte_s1),
		.last_byte  (last_byte_s1),
		.max_offset (max_offset_q),
		.res        (res)
	);

	// a new palette write may replace one that is being transferred this edge
	trpp_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance && res.produce),
		.res          (res),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.palette_slot (palette_slot),
		.color_index  (color_index)
	);

endmodule

`default_nettype wire

[rtl/trpp_checker.sv]
// port-level checks for the transfer record palette parser and their bind
`default_nettype none

module trpp_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_stall,
	input  wire logic                          out_valid,
	input  wire logic                          out_stall,
	input  wire logic [trpp_pkg::SLOT_W-1:0]   palette_slot,
	input  wire logic [trpp_pkg::BYTE_W-1:0]   color_index
);

	// a stalled palette write holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(palette_slot) && $stable(color_index))
		else $error("stalled palette write changed");

	// input only backs up behind a stalled palette write
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	// a fresh palette write comes from a byte taken earlier at the input
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("palette write without a matching byte");

endmodule

bind transfer_record_palette_parser trpp_checker u_trpp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.palette_slot (palette_slot),
	.color_index  (color_index)
);

`default_nettype wire
